### src/key_matrix_change_detector_unit_assert.svh
// Assertion macros used by the key matrix change detector sequencer kmcd_scan.
// Each macro expects i_clk and i_rst_n in the scope where it is used.
`ifndef KEY_MATRIX_CHANGE_DETECTOR_UNIT_ASSERT_SVH
`define KEY_MATRIX_CHANGE_DETECTOR_UNIT_ASSERT_SVH

// Same-cycle implication, checked only outside reset.
`define KMCD_ASSERT_NOW(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error(msg);

// Next-cycle implication, checked only outside reset.
`define KMCD_ASSERT_NEXT(label, pre, post, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |=> (post)) \
        else $error(msg);

`endif

### src/kmcd_pkg.sv
package kmcd_pkg;

    // Default geometry of the key matrix.
    localparam int ROW_COUNT_DEF    = 10;
    localparam int COLUMN_COUNT_DEF = 7;

    // Fixed field widths.
    localparam int ROW_W      = 4;
    localparam int COL_IDX_W  = 3;
    localparam int BYTE_W     = 8;
    localparam int CODE_W     = 7;
    localparam int KIND_W     = 2;

    // Saved pattern of a row that was never scanned: no key down.
    localparam logic [BYTE_W-1:0] SAVED_RESET = 8'hFF;

    // Input operation codes.
    localparam logic OP_SCAN  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_PRESS_ON   = 1'b0;
    localparam logic REG_RELEASE_ON = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_PRESS   = 2'd0,
        KIND_RELEASE = 2'd1,
        KIND_QUERY   = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_LOOK,
        ST_EMIT
    } t_state;

    // Event enables from the configuration registers.
    typedef struct packed {
        logic press_on;
        logic release_on;
    } t_cfg;

    // Request from the sequencer to the row memory.
    typedef struct packed {
        logic              rd_en;
        logic [ROW_W-1:0]  rd_row;
        logic              wr_en;
        logic [ROW_W-1:0]  wr_row;
        logic [BYTE_W-1:0] wr_data;
    } t_mem_req;

endpackage

### src/kmcd_ram.sv
module kmcd_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic                                  i_re,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // One write port and one registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### src/kmcd_scan.sv
`include "key_matrix_change_detector_unit_assert.svh"

module kmcd_scan #(
    parameter int ROW_COUNT    = kmcd_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kmcd_pkg::COLUMN_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  kmcd_pkg::t_cfg                  i_cfg,
    // Input word.
    input  logic                            i_in_valid,
    output logic                            o_in_ready,
    input  logic                            i_op,
    input  logic [kmcd_pkg::ROW_W-1:0]      i_row,
    input  logic [kmcd_pkg::BYTE_W-1:0]     i_cols,
    input  logic [kmcd_pkg::CODE_W-1:0]     i_code,
    // Row memory.
    output kmcd_pkg::t_mem_req              o_mem,
    input  logic [kmcd_pkg::BYTE_W-1:0]     i_mem_rdata,
    // Result word.
    output logic                            o_out_valid,
    input  logic                            i_out_ready,
    output kmcd_pkg::t_kind                 o_kind,
    output logic [kmcd_pkg::CODE_W-1:0]     o_code,
    output logic                            o_down,
    output logic                            o_last
);

    localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;
    localparam logic [kmcd_pkg::ROW_W:0] ROW_LIMIT = (kmcd_pkg::ROW_W + 1)'(ROW_COUNT);

    kmcd_pkg::t_state r_state, n_state;

    logic                          r_op;
    logic [kmcd_pkg::ROW_W-1:0]    r_row;
    logic [kmcd_pkg::BYTE_W-1:0]   r_cols;
    logic [kmcd_pkg::CODE_W-1:0]   r_code;
    logic                          r_in_range;
    logic                          r_down, n_down;
    logic [COLUMN_COUNT-1:0]       r_pend, n_pend;
    logic [ROW_COUNT-1:0]          r_valid, n_valid;

    logic                          r_out_valid, n_out_valid;
    kmcd_pkg::t_kind               r_out_kind, n_out_kind;
    logic [kmcd_pkg::CODE_W-1:0]   r_out_code, n_out_code;
    logic                          r_out_down, n_out_down;
    logic                          r_out_last, n_out_last;

    logic                          w_accept;
    logic [kmcd_pkg::ROW_W-1:0]    w_acc_row;
    logic                          w_acc_range;
    logic [kmcd_pkg::BYTE_W-1:0]   w_saved;
    logic [COLUMN_COUNT-1:0]       w_events;
    logic [COLUMN_COUNT-1:0]       w_low_oh;
    logic [COLUMN_COUNT-1:0]       w_rest;
    logic [kmcd_pkg::COL_IDX_W-1:0] w_col;
    logic                          w_out_free;
    logic                          w_load;

    // Accept a word only between items; the row memory is read right away for an in-range row.
    assign o_in_ready  = (r_state == kmcd_pkg::ST_IDLE);
    assign w_accept    = i_in_valid && o_in_ready;
    assign w_acc_row   = (i_op == kmcd_pkg::OP_QUERY) ? i_code[kmcd_pkg::ROW_W-1:0] : i_row;
    assign w_acc_range = ({1'b0, w_acc_row} < ROW_LIMIT);

    // Memory requests: read on accept, write the new byte back during the compare.
    always_comb begin
        o_mem.rd_en   = w_accept && w_acc_range;
        o_mem.rd_row  = w_acc_row;
        o_mem.wr_en   = (r_state == kmcd_pkg::ST_LOOK) && (r_op == kmcd_pkg::OP_SCAN)
                        && r_in_range;
        o_mem.wr_row  = r_row;
        o_mem.wr_data = r_cols;
    end

    // A row never written reads as all keys up.
    assign w_saved = r_valid[r_row[AW-1:0]] ? i_mem_rdata : kmcd_pkg::SAVED_RESET;

    // Changed columns whose event kind is enabled.
    always_comb begin
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            w_events[c] = (r_cols[c] ^ w_saved[c])
                          && (r_cols[c] ? i_cfg.release_on : i_cfg.press_on);
        end
    end

    // Lowest pending column and what remains after it.
    assign w_low_oh = r_pend & (~r_pend + COLUMN_COUNT'(1));
    assign w_rest   = r_pend & ~w_low_oh;

    always_comb begin
        w_col = '0;
        for (int c = 0; c < COLUMN_COUNT; c++) begin
            if (w_low_oh[c]) begin
                w_col = w_col | kmcd_pkg::COL_IDX_W'(c);
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_load     = (r_state == kmcd_pkg::ST_EMIT) && w_out_free;

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            kmcd_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = kmcd_pkg::ST_LOOK;
                end
            end
            kmcd_pkg::ST_LOOK: begin
                if (r_op == kmcd_pkg::OP_QUERY) begin
                    n_state = kmcd_pkg::ST_EMIT;
                end else if (r_in_range && (w_events != '0)) begin
                    n_state = kmcd_pkg::ST_EMIT;
                end else begin
                    n_state = kmcd_pkg::ST_IDLE;
                end
            end
            kmcd_pkg::ST_EMIT: begin
                if (w_out_free && ((r_op == kmcd_pkg::OP_QUERY) || (w_rest == '0))) begin
                    n_state = kmcd_pkg::ST_IDLE;
                end
            end
            default: n_state = kmcd_pkg::ST_IDLE;
        endcase
    end

    // Pending events, query answer, valid bits and the result register.
    always_comb begin
        n_pend      = r_pend;
        n_down      = r_down;
        n_valid     = r_valid;
        n_out_valid = r_out_valid && !i_out_ready;
        n_out_kind  = r_out_kind;
        n_out_code  = r_out_code;
        n_out_down  = r_out_down;
        n_out_last  = r_out_last;

        if (r_state == kmcd_pkg::ST_LOOK) begin
            n_pend = r_in_range ? w_events : '0;
            n_down = r_in_range && !w_saved[r_code[kmcd_pkg::CODE_W-1:kmcd_pkg::ROW_W]];
        end

        if (o_mem.wr_en) begin
            n_valid[r_row[AW-1:0]] = 1'b1;
        end

        if (w_load) begin
            n_out_valid = 1'b1;
            if (r_op == kmcd_pkg::OP_QUERY) begin
                n_out_kind = kmcd_pkg::KIND_QUERY;
                n_out_code = r_code;
                n_out_down = r_down;
                n_out_last = 1'b1;
            end else begin
                n_out_kind = r_cols[w_col] ? kmcd_pkg::KIND_RELEASE : kmcd_pkg::KIND_PRESS;
                n_out_code = {w_col, r_row};
                n_out_down = 1'b0;
                n_out_last = (w_rest == '0);
                n_pend     = w_rest;
            end
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= kmcd_pkg::ST_IDLE;
            r_valid     <= '0;
            r_out_valid <= 1'b0;
            r_pend      <= '0;
        end else begin
            r_state     <= n_state;
            r_valid     <= n_valid;
            r_out_valid <= n_out_valid;
            r_pend      <= n_pend;
        end
    end

    // Payload registers; the row kept is the one the memory was read at.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_op       <= i_op;
            r_row      <= w_acc_row;
            r_cols     <= i_cols;
            r_code     <= i_code;
            r_in_range <= w_acc_range;
        end
        r_down     <= n_down;
        r_out_kind <= n_out_kind;
        r_out_code <= n_out_code;
        r_out_down <= n_out_down;
        r_out_last <= n_out_last;
    end

    assign o_out_valid = r_out_valid;
    assign o_kind      = r_out_kind;
    assign o_code      = r_out_code;
    assign o_down      = r_out_down;
    assign o_last      = r_out_last;

    // A query answers with exactly one word, which therefore closes the item.
    `KMCD_ASSERT_NOW(a_query_last, r_out_valid && (r_out_kind == kmcd_pkg::KIND_QUERY), r_out_last, "query answer without last")
    // The row memory is only written back by an in-range scan after its read.
    `KMCD_ASSERT_NOW(a_write_scan, o_mem.wr_en, (r_state == kmcd_pkg::ST_LOOK) && (r_op == kmcd_pkg::OP_SCAN) && r_in_range, "row write outside scan compare")
    // Loading the final event of a scan leaves nothing pending.
    `KMCD_ASSERT_NEXT(a_last_drains, w_load && (r_op == kmcd_pkg::OP_SCAN) && (w_rest == '0), (r_pend == '0) && (r_state == kmcd_pkg::ST_IDLE), "events left after last")
    // No read of the row memory while an item is still being worked on.
    `KMCD_ASSERT_NOW(a_read_idle, o_mem.rd_en, r_state == kmcd_pkg::ST_IDLE, "row read during an item")

endmodule

### src/key_matrix_change_detector_unit.sv
// Key matrix change detector. The block keeps the last sampled, active-low
// column byte of every matrix row in a small row memory. A scan word (tuser 0)
// is compared with its row's saved byte, and one press or release word is sent
// per enabled change in the low COLUMN_COUNT columns, lowest column first, the
// final one with tlast; the byte is stored back at the compare. A query word
// (tuser 1) gets a single answer telling whether the addressed key is down.
// Rows at or beyond ROW_COUNT are ignored by scans and read as up by queries.
// A word is taken, the row memory is read, then each result is loaded into the
// output register, which an output stall holds. No new word is taken until
// the item is done. The row memory is read once per in-range item and written
// back once per in-range scan. Event enables are to be written over the
// register port only while the block is idle; the block does not enforce it.
module key_matrix_change_detector_unit #(
    parameter int ROW_COUNT    = kmcd_pkg::ROW_COUNT_DEF,
    parameter int COLUMN_COUNT = kmcd_pkg::COLUMN_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Register port.
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // Input stream.
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [23:0] s_axis_tdata,   // row_index[3:0], column_bits[11:4], query_code[18:12]
    input  logic [0:0]  s_axis_tuser,   // op[0]
    // Result stream.
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // key_code[6:0], key_is_down[7]
    output logic [1:0]  m_axis_tuser,   // kind[1:0]
    output logic        m_axis_tlast
);

    localparam int AW = (ROW_COUNT > 1) ? $clog2(ROW_COUNT) : 1;

    logic               r_press_on;
    logic               r_release_on;
    logic               w_cfg_write;
    kmcd_pkg::t_cfg     w_cfg;
    kmcd_pkg::t_mem_req w_mem;
    logic [kmcd_pkg::BYTE_W-1:0] w_mem_rdata;
    kmcd_pkg::t_kind    w_kind;
    logic [kmcd_pkg::CODE_W-1:0] w_code;
    logic               w_down;

    // Register port: writes complete in the access cycle, never stalled.
    assign pready      = 1'b1;
    assign w_cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_press_on   <= 1'b0;
            r_release_on <= 1'b0;
        end else if (w_cfg_write) begin
            if (paddr[2] == kmcd_pkg::REG_PRESS_ON) begin
                r_press_on <= pwdata[0];
            end else begin
                r_release_on <= pwdata[0];
            end
        end
    end

    assign prdata = {31'd0, (paddr[2] == kmcd_pkg::REG_RELEASE_ON) ? r_release_on : r_press_on};

    assign w_cfg.press_on   = r_press_on;
    assign w_cfg.release_on = r_release_on;

    // Sequencer: compare, write back, emit.
    kmcd_scan #(
        .ROW_COUNT    (ROW_COUNT),
        .COLUMN_COUNT (COLUMN_COUNT)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_op        (s_axis_tuser[0]),
        .i_row       (s_axis_tdata[3:0]),
        .i_cols      (s_axis_tdata[11:4]),
        .i_code      (s_axis_tdata[18:12]),
        .o_mem       (w_mem),
        .i_mem_rdata (w_mem_rdata),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_kind      (w_kind),
        .o_code      (w_code),
        .o_down      (w_down),
        .o_last      (m_axis_tlast)
    );

    // Saved column bytes, one entry per row.
    kmcd_ram #(
        .WIDTH (kmcd_pkg::BYTE_W),
        .DEPTH (ROW_COUNT)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (w_mem.wr_en),
        .i_waddr (w_mem.wr_row[AW-1:0]),
        .i_wdata (w_mem.wr_data),
        .i_re    (w_mem.rd_en),
        .i_raddr (w_mem.rd_row[AW-1:0]),
        .o_rdata (w_mem_rdata)
    );

    assign m_axis_tdata = {w_down, w_code};
    assign m_axis_tuser = w_kind;

endmodule
